// File: design/ccq_pkg.sv
// ----------------------------------------------------------------------------
// ccq_pkg: shared types and constants for the colour classifier
// Class codes, configuration register indexes, reset values and offsets.
// ----------------------------------------------------------------------------
package ccq_pkg;

	typedef enum logic [2:0] {
		CLS_NONE   = 3'd0,
		CLS_RED    = 3'd1,
		CLS_BLUE   = 3'd2,
		CLS_GREEN  = 3'd3,
		CLS_YELLOW = 3'd4
	} class_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_NEEDED = 2'd2;

	localparam logic [13:0] MARGIN_RST        = 14'd200;
	localparam logic [1:0]  YELLOW_FACTOR_RST = 2'd3;
	localparam logic [7:0]  REPEAT_NEEDED_RST = 8'd5;

	localparam logic [15:0] RED_OFFSET       = 16'd300;
	localparam logic [15:0] BLUE_OFFSET      = 16'd250;
	localparam logic [1:0]  YELLOW_RED_SCALE = 2'd3;

	// signed compare width: 16-bit counts against thresholds down to -114681
	localparam int CMP_W = 19;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [13:0] margin;
		logic [1:0]  yellow_factor;
		logic [7:0]  repeat_needed;
	} cfg_t;

endpackage

// File: design/rgb_colour_classifier_qualified_unit.sv
// ----------------------------------------------------------------------------
// rgb_colour_classifier_qualified_unit: colour classifier with run qualification
// Path from input request to result request: the queue, then the result reg.
// Throughput: one sample per cycle while the queue is not full; the run tracker updates once per sample.
// A queue of QUEUE_DEPTH classes lets intake continue while results stall.
// Reset: asynchronous, clears queue, run state and result valid; registers
// return to margin 200, yellow factor 3, repeat count 5.
// ----------------------------------------------------------------------------
module rgb_colour_classifier_qualified_unit import ccq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,   // red_count, green_count, blue_count
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // sample_class, decided, decided_colour
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	class_t push_class;
	class_t head_class;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.margin        <= MARGIN_RST;
			cfg_q.yellow_factor <= YELLOW_FACTOR_RST;
			cfg_q.repeat_needed <= REPEAT_NEEDED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MARGIN:        cfg_q.margin        <= cfg_data;
				CFG_YELLOW_FACTOR: cfg_q.yellow_factor <= cfg_data[1:0];
				CFG_REPEAT_NEEDED: cfg_q.repeat_needed <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ccq_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_class  (push_class)
	);

	ccq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_class (push_class),
		.pop        (q_pop),
		.head_class (head_class),
		.full       (q_full),
		.empty      (q_empty)
	);

	ccq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_class  (head_class),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: design/ccq_front.sv
// ----------------------------------------------------------------------------
// ccq_front: sample intake and classification
// Applies channel offsets and the margin tests, pushes the class to the queue.
// ----------------------------------------------------------------------------
module ccq_front import ccq_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // red_count, green_count, blue_count
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        q_push,
	output class_t      q_class
);

	logic [15:0] r_adj;
	logic [15:0] b_adj;
	logic [15:0] my;
	logic [15:0] m3;
	logic [16:0] my2_m;
	logic signed [CMP_W-1:0] r_s, g_s, b_s, m_s, my_s, m3_s, my2m_s;
	logic yellow_hit, red_hit, blue_hit, green_hit;

	assign r_adj = s_tdata[15:0] - RED_OFFSET;
	assign b_adj = s_tdata[47:32] + BLUE_OFFSET;

	assign my    = 16'(cfg.margin * cfg.yellow_factor);
	assign m3    = 16'(cfg.margin * YELLOW_RED_SCALE);
	assign my2_m = {my, 1'b0} + {3'b000, cfg.margin};

	assign r_s    = signed'({3'b000, r_adj});
	assign g_s    = signed'({3'b000, s_tdata[31:16]});
	assign b_s    = signed'({3'b000, b_adj});
	assign m_s    = signed'({5'b00000, cfg.margin});
	assign my_s   = signed'({3'b000, my});
	assign m3_s   = signed'({3'b000, m3});
	assign my2m_s = signed'({2'b00, my2_m});

	assign yellow_hit = (b_s < g_s - my_s) && (b_s < r_s - m3_s) && (r_s > g_s - my2m_s);
	assign red_hit    = (r_s - m_s > g_s) && (r_s - m_s > b_s);
	assign blue_hit   = (b_s - m_s > g_s) && (r_s < b_s - m_s);
	assign green_hit  = (b_s < g_s - m_s) && (r_s < g_s - m_s);

	always_comb begin
		if (yellow_hit) begin
			q_class = CLS_YELLOW;
		end else if (red_hit) begin
			q_class = CLS_RED;
		end else if (blue_hit) begin
			q_class = CLS_BLUE;
		end else if (green_hit) begin
			q_class = CLS_GREEN;
		end else begin
			q_class = CLS_NONE;
		end
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

endmodule

// File: design/ccq_queue.sv
// ----------------------------------------------------------------------------
// ccq_queue: short class queue
// Decouples the classifier from the run tracker; push and pop in one cycle.
// ----------------------------------------------------------------------------
module ccq_queue import ccq_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  class_t push_class,
	input  logic   pop,
	output class_t head_class,
	output logic   full,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	class_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign empty      = (count_q == '0);
	assign head_class = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_class;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("queue count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full && !pop))
		else $error("push into full queue");

endmodule

// File: design/ccq_back.sv
// ----------------------------------------------------------------------------
// ccq_back: run qualification and result register
// Tracks candidate colour and run length, reports when the run is long enough.
// ----------------------------------------------------------------------------
module ccq_back import ccq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_empty,
	input  class_t     q_class,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // sample_class[2:0], decided[3], decided_colour[6:4]
);

	class_t      cand_q;
	logic [7:0]  run_q;
	logic        valid_q;
	class_t      class_q;
	logic        dec_q;
	class_t      dcol_q;

	logic [7:0]  run_next;
	logic        dec_next;

	assign q_pop = !q_empty && (!valid_q || m_tready);

	always_comb begin
		if (q_class != cand_q) begin
			run_next = 8'd1;
		end else if (run_q != 8'hFF) begin
			run_next = run_q + 8'd1;
		end else begin
			run_next = run_q;
		end
		dec_next = (q_class != CLS_NONE) && (run_next >= cfg.repeat_needed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q  <= CLS_NONE;
			run_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				if (dec_next) begin
					cand_q <= CLS_NONE;
					run_q  <= '0;
				end else if (q_class != CLS_NONE) begin
					cand_q <= q_class;
					run_q  <= run_next;
				end
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			class_q <= q_class;
			dec_q   <= dec_next;
			dcol_q  <= dec_next ? q_class : CLS_NONE;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, dcol_q, dec_q, class_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && dec_q |-> dcol_q == class_q && class_q != CLS_NONE)
		else $error("decided colour differs from sample class");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !dec_q |-> dcol_q == CLS_NONE)
		else $error("colour reported without decision");
	assert property (@(posedge clk) disable iff (!arst_n)
		(run_q == '0) == (cand_q == CLS_NONE))
		else $error("run count and candidate out of step");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && dec_next |=> run_q == '0 && cand_q == CLS_NONE)
		else $error("run not cleared after decision");

endmodule
